@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the Chebyshev third-kind evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge and held off during reset.
`define CHK_IMPLY(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge and held off during reset.
`define CHK_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cheb3_pkg.sv @@
// Package with the types and constants of the Chebyshev third-kind evaluator.
`timescale 1ns / 1ps

package cheb3_pkg;

  localparam int MAX_DEGREE_DEF = 1023;
  localparam int FRAC_BITS      = 28;

  localparam int X_W    = 32;
  localparam int DEG_W  = 11;
  localparam int VAL_W  = 64;
  localparam int TWOX_W = X_W + 1;
  localparam int PROD_W = TWOX_W + VAL_W;

  localparam logic signed [VAL_W-1:0] ONE     = VAL_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic update;
  } cheb3_ctrl_t;

endpackage

@@ rtl/cheb3_mul_unit.sv @@
// Shared multiply, shift, saturate and subtract unit that runs one recurrence step.
`timescale 1ns / 1ps

module cheb3_mul_unit (
  input  logic                                    clk,
  input  cheb3_pkg::cheb3_ctrl_t                  ctrl,
  input  logic signed [cheb3_pkg::X_W-1:0]        arg_x,
  output logic signed [cheb3_pkg::VAL_W-1:0]      v1,
  output logic                                    sat
);

  logic signed [cheb3_pkg::TWOX_W-1:0]   two_x;
  logic signed [cheb3_pkg::VAL_W-1:0]    v0;
  logic signed [cheb3_pkg::PROD_W-1:0]   acc;

  logic signed [cheb3_pkg::TWOX_W-1:0]   mul_b;
  logic signed [2*cheb3_pkg::TWOX_W-1:0] prod;
  logic signed [cheb3_pkg::PROD_W-1:0]   acc_sum;
  logic signed [cheb3_pkg::PROD_W-1:0]   shifted;
  logic                                  prod_ovf;
  logic signed [cheb3_pkg::VAL_W-1:0]    prod_sat;
  logic signed [cheb3_pkg::VAL_W:0]      diff;
  logic                                  sub_ovf;
  logic signed [cheb3_pkg::VAL_W-1:0]    vn;

  always_comb begin
    if (ctrl.mul_hi) begin
      mul_b = $signed({v1[cheb3_pkg::VAL_W-1], v1[63:32]});
    end else begin
      mul_b = $signed({1'b0, v1[31:0]});
    end
    prod     = two_x * mul_b;
    acc_sum  = acc + (cheb3_pkg::PROD_W'(prod) <<< 32);
    shifted  = acc >>> cheb3_pkg::FRAC_BITS;
    prod_ovf = !((&shifted[cheb3_pkg::PROD_W-1:cheb3_pkg::VAL_W-1]) ||
                 !(|shifted[cheb3_pkg::PROD_W-1:cheb3_pkg::VAL_W-1]));
    if (prod_ovf) begin
      prod_sat = shifted[cheb3_pkg::PROD_W-1] ? cheb3_pkg::VAL_MIN : cheb3_pkg::VAL_MAX;
    end else begin
      prod_sat = shifted[cheb3_pkg::VAL_W-1:0];
    end
    diff    = {prod_sat[cheb3_pkg::VAL_W-1], prod_sat} - {v0[cheb3_pkg::VAL_W-1], v0};
    sub_ovf = diff[cheb3_pkg::VAL_W] != diff[cheb3_pkg::VAL_W-1];
    if (sub_ovf) begin
      vn = diff[cheb3_pkg::VAL_W] ? cheb3_pkg::VAL_MIN : cheb3_pkg::VAL_MAX;
    end else begin
      vn = diff[cheb3_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      two_x <= $signed({arg_x, 1'b0});
      v0    <= cheb3_pkg::ONE;
      v1    <= cheb3_pkg::VAL_W'($signed({arg_x, 1'b0})) - cheb3_pkg::ONE;
      sat   <= 1'b0;
    end
    if (ctrl.mul_lo) begin
      acc <= cheb3_pkg::PROD_W'(prod);
    end
    if (ctrl.mul_hi) begin
      acc <= acc_sum;
    end
    if (ctrl.update) begin
      v0  <= v1;
      v1  <= vn;
      sat <= sat | prod_ovf | sub_ovf;
    end
  end

endmodule

@@ rtl/chebyshev_third_kind_eval.sv @@
// Top level of the Chebyshev third-kind evaluator: sequencer, special cases and output register.
//
//   channel | direction | handshake           | beat fields
//   in      | input     | in_valid, in_ready   | arg_x, degree
//   out     | output    | out_valid, out_ready | value, overflow
//
// A beat with degree n >= 2 and no special argument runs n-1 recurrence steps from accept
// to the result register; every other beat goes from idle straight to the finish state.
// Each recurrence step runs the one 33x33 multiplier path through MUL_LO, MUL_HI and UPDATE:
// low half, high half with accumulate, then shift, saturate and subtract.
// Reset clears the sequencer and the output valid.
// The input is ready only when the sequencer is idle, and a finished result waits in
// the finish state while the output register still holds an untaken beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chebyshev_third_kind_eval #(
  parameter int MAX_DEGREE = cheb3_pkg::MAX_DEGREE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cheb3_pkg::X_W-1:0]     arg_x,
  input  logic signed [cheb3_pkg::DEG_W-1:0]   degree,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cheb3_pkg::VAL_W-1:0]   value,
  output logic                                 overflow
);

  localparam int CNT_W = $clog2(MAX_DEGREE + 1);

  cheb3_pkg::state_t      state;
  cheb3_pkg::state_t      state_next;
  cheb3_pkg::cheb3_ctrl_t ctrl;

  logic [CNT_W-1:0]                   rem;
  logic                               special;
  logic signed [cheb3_pkg::VAL_W-1:0] spec_value;
  logic                               out_load;
  logic                               accept;

  logic [CNT_W-1:0]                   n_clamp;
  logic                               deg_neg;
  logic                               x_one;
  logic                               x_mone;
  logic                               special_in;
  logic signed [cheb3_pkg::VAL_W-1:0] m_mag;
  logic signed [cheb3_pkg::VAL_W-1:0] spec_in;

  logic signed [cheb3_pkg::VAL_W-1:0] v1;
  logic                               sat;

  cheb3_mul_unit u_mul (
    .clk   (clk),
    .ctrl  (ctrl),
    .arg_x (arg_x),
    .v1    (v1),
    .sat   (sat)
  );

  always_comb begin
    deg_neg = degree[cheb3_pkg::DEG_W-1];
    if (int'(degree[cheb3_pkg::DEG_W-2:0]) > MAX_DEGREE) begin
      n_clamp = CNT_W'(MAX_DEGREE);
    end else begin
      n_clamp = CNT_W'(degree[cheb3_pkg::DEG_W-2:0]);
    end
    x_one  = cheb3_pkg::VAL_W'(arg_x) == cheb3_pkg::ONE;
    x_mone = cheb3_pkg::VAL_W'(arg_x) == -cheb3_pkg::ONE;
    m_mag  = cheb3_pkg::VAL_W'({n_clamp, 1'b1}) <<< cheb3_pkg::FRAC_BITS;
    special_in = deg_neg || x_one || x_mone || (n_clamp == '0);
    priority if (deg_neg) begin
      spec_in = '0;
    end else if (x_one) begin
      spec_in = cheb3_pkg::ONE;
    end else if (x_mone) begin
      spec_in = n_clamp[0] ? -m_mag : m_mag;
    end else begin
      spec_in = cheb3_pkg::ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cheb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      cheb3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          if (special_in || n_clamp == CNT_W'(1)) begin
            state_next = cheb3_pkg::ST_FINISH;
          end else begin
            state_next = cheb3_pkg::ST_MUL_LO;
          end
        end
      end
      cheb3_pkg::ST_MUL_LO: begin
        ctrl.mul_lo = 1'b1;
        state_next  = cheb3_pkg::ST_MUL_HI;
      end
      cheb3_pkg::ST_MUL_HI: begin
        ctrl.mul_hi = 1'b1;
        state_next  = cheb3_pkg::ST_UPDATE;
      end
      cheb3_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
        if (rem == CNT_W'(1)) begin
          state_next = cheb3_pkg::ST_FINISH;
        end else begin
          state_next = cheb3_pkg::ST_MUL_LO;
        end
      end
      cheb3_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = cheb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cheb3_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      rem        <= n_clamp - CNT_W'(1);
      special    <= special_in;
      spec_value <= spec_in;
    end else if (ctrl.update) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value    <= special ? spec_value : v1;
      overflow <= special ? 1'b0 : sat;
    end
  end

  `CHK_NEXT(a_busy_after_accept, clk, rst, accept, !in_ready, "ready after accept")
  `CHK_IMPLY(a_update_count, clk, rst, state == cheb3_pkg::ST_UPDATE, rem != '0, "no steps left")
  `CHK_NEXT(a_neg_short, clk, rst, accept && deg_neg, state == cheb3_pkg::ST_FINISH, "negative n")
  `CHK_IMPLY(a_special_clean, clk, rst, $rose(out_valid) && special, !overflow, "special overflow")

endmodule

@@ test/chebyshev_third_kind_eval_test.sv @@
// Self-checking testbench for the Chebyshev third-kind evaluator.
`timescale 1ns / 1ps

module chebyshev_third_kind_eval_test;

  localparam int ONE_X = 1 << cheb3_pkg::FRAC_BITS;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3100;
  localparam int BEATS_PER_PHASE = 139;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [cheb3_pkg::VAL_W-1:0] value;
    logic                               overflow;
  } v3_beat_t;

  class cheb3_scoreboard;
    v3_beat_t pending_values[$];
    int errors;
    int beats_in;
    int saturated_results;
    bit saturated;

    function logic signed [cheb3_pkg::VAL_W-1:0] scaled_product(
        logic signed [cheb3_pkg::TWOX_W-1:0] two_x,
        logic signed [cheb3_pkg::VAL_W-1:0] v);
      wide_t p;
      p = (wide_t'(two_x) * wide_t'(v)) >>> cheb3_pkg::FRAC_BITS;
      if (p > wide_t'(cheb3_pkg::VAL_MAX)) begin
        saturated = 1'b1;
        return cheb3_pkg::VAL_MAX;
      end
      if (p < wide_t'(cheb3_pkg::VAL_MIN)) begin
        saturated = 1'b1;
        return cheb3_pkg::VAL_MIN;
      end
      return p[cheb3_pkg::VAL_W-1:0];
    endfunction

    function logic signed [cheb3_pkg::VAL_W-1:0] clamped_diff(
        logic signed [cheb3_pkg::VAL_W-1:0] a,
        logic signed [cheb3_pkg::VAL_W-1:0] b);
      logic signed [cheb3_pkg::VAL_W:0] d;
      d = (cheb3_pkg::VAL_W+1)'(a) - (cheb3_pkg::VAL_W+1)'(b);
      if (d[cheb3_pkg::VAL_W] != d[cheb3_pkg::VAL_W-1]) begin
        saturated = 1'b1;
        return d[cheb3_pkg::VAL_W] ? cheb3_pkg::VAL_MIN : cheb3_pkg::VAL_MAX;
      end
      return d[cheb3_pkg::VAL_W-1:0];
    endfunction

    function void note_input(logic signed [cheb3_pkg::X_W-1:0] x,
                             logic signed [cheb3_pkg::DEG_W-1:0] n);
      v3_beat_t e;
      int deg;
      logic signed [cheb3_pkg::TWOX_W-1:0] two_x;
      logic signed [cheb3_pkg::VAL_W-1:0] v_prev, v_cur, v_next, m;
      beats_in++;
      saturated = 1'b0;
      e.overflow = 1'b0;
      deg = n;
      if (deg > cheb3_pkg::MAX_DEGREE_DEF) deg = cheb3_pkg::MAX_DEGREE_DEF;
      if (deg < 0) begin
        e.value = '0;
      end else if (cheb3_pkg::VAL_W'(x) == cheb3_pkg::ONE) begin
        e.value = cheb3_pkg::ONE;
      end else if (cheb3_pkg::VAL_W'(x) == -cheb3_pkg::ONE) begin
        m = cheb3_pkg::VAL_W'(2 * deg + 1) <<< cheb3_pkg::FRAC_BITS;
        e.value = deg[0] ? -m : m;
      end else if (deg == 0) begin
        e.value = cheb3_pkg::ONE;
      end else begin
        two_x = cheb3_pkg::TWOX_W'(x) <<< 1;
        v_prev = cheb3_pkg::ONE;
        v_cur = cheb3_pkg::VAL_W'(two_x) - cheb3_pkg::ONE;
        for (int k = 2; k <= deg; k++) begin
          v_next = clamped_diff(scaled_product(two_x, v_cur), v_prev);
          v_prev = v_cur;
          v_cur = v_next;
        end
        e.value = v_cur;
        e.overflow = saturated;
      end
      if (e.overflow) saturated_results++;
      pending_values.push_back(e);
    endfunction

    function void check_result(logic signed [cheb3_pkg::VAL_W-1:0] value, logic overflow);
      v3_beat_t e;
      if (pending_values.size() == 0) begin
        $error("result beat with no expectation pending: value %0d", value);
        errors++;
        return;
      end
      e = pending_values.pop_front();
      if (value !== e.value) begin
        $error("value mismatch: expected %0d, actual %0d", e.value, value);
        errors++;
      end
      if (overflow !== e.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", e.overflow, overflow);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_values.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [cheb3_pkg::X_W-1:0] arg_x = '0;
  logic signed [cheb3_pkg::DEG_W-1:0] degree = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [cheb3_pkg::VAL_W-1:0] value;
  logic overflow;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  cheb3_scoreboard sb = new();

  chebyshev_third_kind_eval i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .arg_x    (arg_x),
    .degree   (degree),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value),
    .overflow (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(arg_x, degree);
      if (out_valid && out_ready) sb.check_result(value, overflow);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat moved in %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_beat(logic signed [cheb3_pkg::X_W-1:0] x,
                           logic signed [cheb3_pkg::DEG_W-1:0] n);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    arg_x <= x;
    degree <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_beat();
    logic signed [cheb3_pkg::X_W-1:0] x;
    int n;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      x = int'($urandom_range(0, 1 << 29)) - ONE_X;
    end else if (sel < 55) begin
      x = int'($urandom_range(0, 1 << 30)) - (1 << 29);
    end else if (sel < 80) begin
      x = $urandom();
    end else if (sel < 90) begin
      x = $urandom_range(1) ? ONE_X : -ONE_X;
    end else begin
      case ($urandom_range(5))
        0: x = '0;
        1: x = 32'sh7FFF_FFFF;
        2: x = 32'sh8000_0000;
        3: x = ONE_X + 1;
        4: x = -ONE_X - 1;
        default: x = ONE_X - 1;
      endcase
    end
    sel = $urandom_range(99);
    if (sel < 10) n = -int'($urandom_range(1, 1024));
    else if (sel < 75) n = $urandom_range(0, 31);
    else if (sel < 93) n = $urandom_range(32, 255);
    else n = $urandom_range(256, 1023);
    send_beat(x, cheb3_pkg::DEG_W'(n));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(ONE_X, 5);
    send_beat(-ONE_X, 4);
    send_beat(-ONE_X, 7);
    send_beat(-ONE_X, 1023);
    send_beat(ONE_X, 1023);
    send_beat(0, 0);
    send_beat(12345, 0);
    send_beat(0, -1);
    send_beat(ONE_X, -1024);
    send_beat(32'sh7FFF_FFFF, 1);
    send_beat(32'sh8000_0000, 1);
    send_beat(32'sh7FFF_FFFF, 1023);
    send_beat(32'sh8000_0000, 1023);
    send_beat(ONE_X / 2, 2);
    send_beat(-ONE_X / 2, 3);
    send_beat(ONE_X - 1, 40);
    send_beat(-ONE_X + 1, 41);
    send_beat(ONE_X + 1, 60);
    send_beat(-ONE_X - 1, 61);
    send_beat(0, 1023);
    send_beat(3 * (ONE_X / 2), 100);
    send_beat(-1, 2);
    send_beat(1, 2);
    send_beat(32'sh5555_5555, 10);
    send_beat(32'shAAAA_AAAA, 11);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      repeat (BEATS_PER_PHASE) send_random_beat();
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d argument/degree beats, directed corners then random, across four",
             sb.beats_in);
    $display("pacing phases of sender gaps and receiver stalls; %0d results saturated.",
             sb.saturated_results);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cheb3_pkg.sv
rtl/cheb3_mul_unit.sv
rtl/chebyshev_third_kind_eval.sv
test/chebyshev_third_kind_eval_test.sv
